// File: rtl/tbr_pkg.sv
// Shared types and constants of the turbulent breakup rate block.
// No dependencies; every other file of the block uses this package.
package tbr_pkg;

  localparam int WORD_W     = 32;
  localparam int RATE_W     = 48;
  localparam int PROD_W     = 64;
  localparam int EXP_TERMS  = 13;
  localparam int CFG_ADDR_W = 3;

  localparam logic [WORD_W-1:0] RST_BREAKUP_COEFF  = 32'd16777216;
  localparam logic [WORD_W-1:0] RST_CRITICAL_WEBER = 32'd1258291;

  // Register index, taken from byte address bit 2.
  localparam logic REG_BREAKUP_COEFF  = 1'b0;
  localparam logic REG_CRITICAL_WEBER = 1'b1;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  typedef struct packed {
    logic [WORD_W-1:0] weber_number;
    logic [WORD_W-1:0] turb_velocity;
    logic [WORD_W-1:0] diameter;
  } tbr_in_t;

  typedef struct packed {
    logic [RATE_W-1:0] breakup_rate;
    logic              above_critical;
    logic              saturated;
  } tbr_out_t;

endpackage

// File: rtl/tbr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Uses tbr_pkg only for its default widths.
module tbr_div_pipe #(
  parameter int DW = tbr_pkg::WORD_W,
  parameter int QW = tbr_pkg::WORD_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [DW-1:0] in_high,
  input  logic [QW-1:0] in_low,
  input  logic [DW-1:0] in_divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  // The high part must be below the divisor; the quotient then fits QW bits.
  logic [QW-1:0] vld_r;
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] lo_r   [QW];
  logic [DW-1:0] dvs_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic          vld_p;
    logic [DW-1:0] rem_p;
    logic [QW-1:0] lo_p;
    logic [DW-1:0] dvs_p;
    logic [SW-1:0] side_p;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign vld_p  = in_valid;
      assign rem_p  = in_high;
      assign lo_p   = in_low;
      assign dvs_p  = in_divisor;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[i-1];
      assign rem_p  = rem_r[i-1];
      assign lo_p   = lo_r[i-1];
      assign dvs_p  = dvs_r[i-1];
      assign side_p = side_r[i-1];
    end

    always_comb begin
      trial = {rem_p, lo_p[QW-1]};
      diff  = trial - {1'b0, dvs_p};
      ge    = (trial >= {1'b0, dvs_p});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_p;
      end
      rem_r[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      lo_r[i]   <= {lo_p[QW-2:0], ge};
      dvs_r[i]  <= dvs_p;
      side_r[i] <= side_p;
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quot  = lo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// File: rtl/turbulent_breakup_rate.sv
// Top level of the turbulent breakup rate block: register port and pipeline.
// Depends on tbr_pkg and on tbr_div_pipe.
//
// Usage. One mesh cell is a transfer on the input channel: in_data holds the
// Weber number, the turbulent velocity and the particle diameter, and it is
// taken at every rising edge with start high and busy low. Busy stays low,
// so a new cell may be offered in every cycle and the block sustains one
// cell per clock. Each cell gives exactly one result, shown on out_data for
// one cycle with out_valid high; results come out in input order. The
// pipeline is made of the two restoring dividers (32 stages for the Weber
// ratio, 48 for the division by the diameter), the 32-stage square root
// that runs beside the 27-stage exponential series, and seven multiply,
// add and register stages.
// The receiver cannot stall: a result is gone after its cycle, so the
// pipeline simply advances every clock.
// The APB port holds the breakup coefficient at address 0 and the critical
// Weber number at address 4. Write them only while the pipeline is empty.
// A synchronous reset restores both registers and clears every valid bit,
// so nothing that was in flight comes out after reset.
module turbulent_breakup_rate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  tbr_pkg::tbr_in_t                     in_data,
  output logic                                 out_valid,
  output tbr_pkg::tbr_out_t                    out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tbr_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [tbr_pkg::WORD_W-1:0]           pwdata,
  output logic [tbr_pkg::WORD_W-1:0]           prdata,
  output logic                                 pready
);
  import tbr_pkg::*;

  localparam int ESTAGES   = WORD_W;        // one square-root step per stage
  localparam int EXP_LAST  = 2 * EXP_TERMS; // stage that forms exp(-r)
  localparam int DIV1_SW   = 1 + 2 * WORD_W;
  localparam int HIGH_W    = PROD_W - RATE_W;
  localparam logic [WORD_W:0] ONE_Q32 = {1'b1, {WORD_W{1'b0}}};

  // ---------------------------------------------------------------------
  // Configuration registers. The block never pushes back on a transfer.
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0] coeff_r;
  logic [WORD_W-1:0] wecr_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= RST_BREAKUP_COEFF;
      wecr_r  <= RST_CRITICAL_WEBER;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BREAKUP_COEFF:  coeff_r <= pwdata;
        REG_CRITICAL_WEBER: wecr_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BREAKUP_COEFF:  prdata = coeff_r;
      REG_CRITICAL_WEBER: prdata = wecr_r;
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register: capture the cell and the comparison with the critical
  // Weber number.
  // ---------------------------------------------------------------------
  logic              a_valid_r;
  logic              a_above_r;
  logic [WORD_W-1:0] a_we_r;
  logic [WORD_W-1:0] a_ut_r;
  logic [WORD_W-1:0] a_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start & ~busy;
    end
    a_above_r <= (in_data.weber_number > wecr_r);
    a_we_r    <= in_data.weber_number;
    a_ut_r    <= in_data.turb_velocity;
    a_d_r     <= in_data.diameter;
  end

  // ---------------------------------------------------------------------
  // Ratio r = WeCr * 2^32 / We in Q0.32. Above critical WeCr < We, so the
  // quotient fits 32 bits. Below critical the quotient is never used.
  // ---------------------------------------------------------------------
  logic               d1_valid;
  logic [WORD_W-1:0]  d1_r;
  logic [DIV1_SW-1:0] d1_side;

  tbr_div_pipe #(
    .DW(WORD_W),
    .QW(WORD_W),
    .SW(DIV1_SW)
  ) u_ratio_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid_r),
    .in_high   (wecr_r),
    .in_low    ('0),
    .in_divisor(a_we_r),
    .in_side   ({a_above_r, a_ut_r, a_d_r}),
    .out_valid (d1_valid),
    .out_quot  (d1_r),
    .out_side  (d1_side)
  );

  // ---------------------------------------------------------------------
  // Series stages. Each stage takes one square-root digit of (1 - r)*2^64.
  // Beside it, the exponential series advances one half-term per stage:
  // even stages form term * r / 2^32, odd stages divide by the term number
  // through a reciprocal multiply and add the term to its partial sum.
  // Stage EXP_LAST folds the two partial sums into exp(-r).
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic                valid;
    logic                above;
    logic                rzero;
    logic [WORD_W-1:0]   d;
    logic [WORD_W-1:0]   ut;
    logic [PROD_W-1:0]   p;
    logic [WORD_W-1:0]   r;
    logic [WORD_W:0]     term;
    logic [WORD_W-1:0]   x;
    logic [WORD_W+1:0]   pos;
    logic [WORD_W+1:0]   neg;
    logic [2*WORD_W-1:0] sx;
    logic [WORD_W+2:0]   srem;
    logic [WORD_W-1:0]   sroot;
  } estage_t;

  estage_t e_in;
  estage_t e_r [ESTAGES];

  always_comb begin
    e_in       = '0;
    e_in.valid = d1_valid;
    e_in.above = d1_side[DIV1_SW-1];
    e_in.ut    = d1_side[2*WORD_W-1:WORD_W];
    e_in.d     = d1_side[WORD_W-1:0];
    e_in.r     = d1_r;
    e_in.rzero = (d1_r == '0);
    e_in.term  = ONE_Q32;
    e_in.pos   = {1'b0, ONE_Q32};
    e_in.neg   = '0;
    // 2^32 - r truncated to 32 bits; r of zero is handled by rzero.
    e_in.sx    = {(~d1_r) + 1'b1, {WORD_W{1'b0}}};
  end

  for (genvar j = 0; j < ESTAGES; j++) begin : g_es
    localparam int N = j / 2 + 1;
    localparam int K = WORD_W + $clog2(N);
    localparam logic [2*WORD_W+4:0] MFULL =
      (({{(WORD_W+4){1'b0}}, 1'b1} << K) + (2*WORD_W+5)'(N - 1)) / (2*WORD_W+5)'(N);
    localparam logic [WORD_W:0] M = MFULL[WORD_W:0];

    estage_t           prv;
    estage_t           nxt;
    logic [2*WORD_W:0] tprod;
    logic [2*WORD_W:0] rprod;
    logic [2*WORD_W:0] rshift;
    logic [WORD_W+2:0] rem_t;
    logic [WORD_W+2:0] trial;

    if (j == 0) begin : g_first
      assign prv = e_in;
    end else begin : g_next
      assign prv = e_r[j-1];
    end

    always_comb begin
      nxt    = prv;
      tprod  = prv.term * {1'b0, prv.r};
      rprod  = {1'b0, prv.x} * M;
      rshift = rprod >> K;
      // Square-root digit.
      rem_t  = {prv.srem[WORD_W:0], prv.sx[2*WORD_W-1 -: 2]};
      trial  = {1'b0, prv.sroot, 2'b01};
      nxt.sx = {prv.sx[2*WORD_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        nxt.srem  = rem_t - trial;
        nxt.sroot = {prv.sroot[WORD_W-2:0], 1'b1};
      end else begin
        nxt.srem  = rem_t;
        nxt.sroot = {prv.sroot[WORD_W-2:0], 1'b0};
      end
      if (j == 0) begin
        nxt.p = PROD_W'(prv.ut) * PROD_W'(coeff_r);
      end
      if (j < EXP_LAST) begin
        if ((j % 2) == 0) begin
          nxt.x = tprod[2*WORD_W-1:WORD_W];
        end else begin
          nxt.term = rshift[WORD_W:0];
          if ((N % 2) == 1) begin
            nxt.neg = prv.neg + {1'b0, rshift[WORD_W:0]};
          end else begin
            nxt.pos = prv.pos + {1'b0, rshift[WORD_W:0]};
          end
        end
      end else if (j == EXP_LAST) begin
        nxt.pos = (prv.pos >= prv.neg) ? (prv.pos - prv.neg) : '0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        e_r[j].valid <= 1'b0;
      end else begin
        e_r[j] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Product stages: f = s * e / 2^32, then q = p * f / 2^32 from two
  // 32-bit halves of p, one multiplier per stage.
  // ---------------------------------------------------------------------
  logic                f1_valid_r, f2_valid_r, f3_valid_r, f4_valid_r, f5_valid_r;
  logic                f1_above_r, f2_above_r, f3_above_r, f4_above_r, f5_above_r;
  logic [WORD_W-1:0]   f1_d_r, f2_d_r, f3_d_r, f4_d_r, f5_d_r;
  logic [PROD_W-1:0]   f1_p_r;
  logic [WORD_W-1:0]   f2_phi_r;
  logic [WORD_W:0]     f1_f_r, f2_f_r;
  logic [2*WORD_W:0]   f2_lo_r, f3_lo_r;
  logic [2*WORD_W:0]   f3_hi_r;
  logic [PROD_W-1:0]   f4_q_r, f5_q_r;
  logic                f5_sat_r;
  logic [WORD_W:0]     s_val;
  logic [2*WORD_W+1:0] sf_prod;
  estage_t             e_last;

  assign e_last  = e_r[ESTAGES-1];
  assign s_val   = e_last.rzero ? ONE_Q32 : {1'b0, e_last.sroot};
  assign sf_prod = s_val * e_last.pos[WORD_W:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      f3_valid_r <= 1'b0;
      f4_valid_r <= 1'b0;
      f5_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= e_last.valid;
      f2_valid_r <= f1_valid_r;
      f3_valid_r <= f2_valid_r;
      f4_valid_r <= f3_valid_r;
      f5_valid_r <= f4_valid_r;
    end
    f1_above_r <= e_last.above;
    f1_d_r     <= e_last.d;
    f1_p_r     <= e_last.p;
    f1_f_r     <= sf_prod[2*WORD_W:WORD_W];

    f2_above_r <= f1_above_r;
    f2_d_r     <= f1_d_r;
    f2_phi_r   <= f1_p_r[PROD_W-1:WORD_W];
    f2_f_r     <= f1_f_r;
    f2_lo_r    <= f1_p_r[WORD_W-1:0] * f1_f_r;

    f3_above_r <= f2_above_r;
    f3_d_r     <= f2_d_r;
    f3_lo_r    <= f2_lo_r;
    f3_hi_r    <= f2_phi_r * f2_f_r;

    f4_above_r <= f3_above_r;
    f4_d_r     <= f3_d_r;
    f4_q_r     <= f3_hi_r[PROD_W-1:0] + {{WORD_W{1'b0}}, f3_lo_r[2*WORD_W-1:WORD_W]};

    // The quotient by d overflows 48 bits exactly when q / 2^48 >= d.
    f5_above_r <= f4_above_r;
    f5_d_r     <= f4_d_r;
    f5_q_r     <= f4_q_r;
    f5_sat_r   <= (f4_d_r == '0) ||
                  ({{(WORD_W-HIGH_W){1'b0}}, f4_q_r[PROD_W-1:RATE_W]} >= f4_d_r);
  end

  // ---------------------------------------------------------------------
  // Division by the diameter, 48 quotient bits.
  // ---------------------------------------------------------------------
  logic              d2_valid;
  logic [RATE_W-1:0] d2_quot;
  logic [1:0]        d2_side;

  tbr_div_pipe #(
    .DW(WORD_W),
    .QW(RATE_W),
    .SW(2)
  ) u_diam_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f5_valid_r),
    .in_high   ({{(WORD_W-HIGH_W){1'b0}}, f5_q_r[PROD_W-1:RATE_W]}),
    .in_low    (f5_q_r[RATE_W-1:0]),
    .in_divisor(f5_d_r),
    .in_side   ({f5_above_r, f5_sat_r}),
    .out_valid (d2_valid),
    .out_quot  (d2_quot),
    .out_side  (d2_side)
  );

  // ---------------------------------------------------------------------
  // Output register. Below critical the result is zero with no flags.
  // ---------------------------------------------------------------------
  logic     out_valid_r;
  tbr_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d2_valid;
    end
    out_data_r.above_critical <= d2_side[1];
    out_data_r.saturated      <= d2_side[1] & d2_side[0];
    if (!d2_side[1]) begin
      out_data_r.breakup_rate <= '0;
    end else if (d2_side[0]) begin
      out_data_r.breakup_rate <= RATE_MAX;
    end else begin
      out_data_r.breakup_rate <= d2_quot;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the turbulent breakup rate block.
// Depends on tbr_pkg and on the turbulent_breakup_rate top level only.
module tb_top;
  import tbr_pkg::*;

  // The drain pause and the settle time before register writes allow a bit
  // more than the pipeline of the block takes to answer a cell.
  localparam int          PIPE_SETTLE = 130;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          IDLE_PCT    = 18;
  localparam logic [63:0] ONE_Q32     = 64'h1_0000_0000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  tbr_in_t               in_data;
  logic                  out_valid;
  tbr_out_t              out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [WORD_W-1:0]     pwdata;
  logic [WORD_W-1:0]     prdata;
  logic                  pready;

  // Shadow copy of the two configuration registers, used by the predictor.
  logic [WORD_W-1:0] coeff_shadow;
  logic [WORD_W-1:0] crit_shadow;

  // Expected results, oldest first, and the bookkeeping of the run.
  tbr_out_t rate_queue[$];
  int       error_count;
  int       cycle_count;
  int       cells_sent;
  int       rates_checked;
  int       above_seen;
  int       sat_seen;
  bit       no_idle;

  turbulent_breakup_rate u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Watchdog: a hung pipeline or handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Integer square root of a 64-bit value, bit by bit.
  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // floor(p * f / 2^32) for a Q0.32 factor f of at most one.
  function automatic logic [63:0] scale_q32(logic [63:0] p, logic [63:0] f);
    logic [127:0] wide;
    if (f >= ONE_Q32) return p;
    wide = {64'd0, p} * {64'd0, f};
    return wide[95:32];
  endfunction

  // Breakup rate of one cell under the current register values. The ratio
  // r = WeCr/We drives a truncated exp(-r) series and sqrt(1-r); their
  // product scales Cti*Ut, which is then divided by the diameter.
  function automatic tbr_out_t predict_rate(tbr_in_t c);
    logic [63:0] we;
    logic [63:0] wecr;
    logic [63:0] ratio;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] ex;
    logic [63:0] sq;
    logic [63:0] rem;
    logic [63:0] prod;
    logic [63:0] q;
    logic [63:0] rate;
    tbr_out_t    res;
    res  = '0;
    we   = {32'd0, c.weber_number};
    wecr = {32'd0, crit_shadow};
    if (we <= wecr) return res;
    ratio = (wecr << 32) / we;
    term  = ONE_Q32;
    pos   = ONE_Q32;
    neg   = '0;
    for (int n = 1; n <= EXP_TERMS; n++) begin
      term = ((term * ratio) >> 32) / 64'(n);
      if (n % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    ex  = (pos >= neg) ? pos - neg : 64'd0;
    rem = ONE_Q32 - ratio;
    sq  = (rem >= ONE_Q32) ? ONE_Q32 : root64(rem << 32);
    prod = {32'd0, coeff_shadow} * {32'd0, c.turb_velocity};
    q    = scale_q32(prod, scale_q32(sq, ex));
    res.above_critical = 1'b1;
    if (c.diameter == 0) begin
      res.breakup_rate = RATE_MAX;
      res.saturated    = 1'b1;
    end else begin
      rate = q / {32'd0, c.diameter};
      if (rate > {16'd0, RATE_MAX}) begin
        res.breakup_rate = RATE_MAX;
        res.saturated    = 1'b1;
      end else begin
        res.breakup_rate = rate[RATE_W-1:0];
      end
    end
    return res;
  endfunction

  // Results are stable for the whole strobe cycle, so they are sampled at the
  // falling edge, before the rising edge that ends the transfer.
  always @(negedge clk) begin
    tbr_out_t want;
    if (rst_n && out_valid) begin
      if (rate_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        want = rate_queue.pop_front();
        rates_checked++;
        if (want.above_critical) above_seen++;
        if (want.saturated) sat_seen++;
        if (out_data.breakup_rate !== want.breakup_rate) begin
          $display("%0t: breakup_rate expected %h actual %h", $time,
                   want.breakup_rate, out_data.breakup_rate);
          error_count++;
        end
        if (out_data.above_critical !== want.above_critical) begin
          $display("%0t: above_critical expected %b actual %b", $time,
                   want.above_critical, out_data.above_critical);
          error_count++;
        end
        if (out_data.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time,
                   want.saturated, out_data.saturated);
          error_count++;
        end
      end
    end
  end

  // Offers one cell, waits for the rising edge of its transfer, then may leave idle cycles.
  // Busy is sampled at the falling edge, when it is settled for that edge.
  task automatic send_cell(tbr_in_t c);
    bit taken;
    start   <= 1'b1;
    in_data <= c;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    rate_queue.push_back(predict_rate(c));
    cells_sent++;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Waits until every expected result has come and the pipeline is empty.
  task automatic drain_pipe();
    start <= 1'b0;
    while (rate_queue.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // APB write of one register, followed by a read back of the same address.
  task automatic write_reg(logic idx, logic [WORD_W-1:0] value);
    logic [CFG_ADDR_W-1:0] addr;
    addr = CFG_ADDR_W'({idx, 2'b00});
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== value) begin
      $display("%0t: register %0d read back expected %h actual %h", $time,
               idx, value, prdata);
      error_count++;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_BREAKUP_COEFF) coeff_shadow = value;
    else crit_shadow = value;
  endtask

  task automatic set_config(logic [WORD_W-1:0] coeff, logic [WORD_W-1:0] crit);
    drain_pipe();
    write_reg(REG_BREAKUP_COEFF, coeff);
    write_reg(REG_CRITICAL_WEBER, crit);
  endtask

  function automatic tbr_in_t make_cell(logic [WORD_W-1:0] we, logic [WORD_W-1:0] ut,
                                        logic [WORD_W-1:0] d);
    tbr_in_t c;
    c.weber_number  = we;
    c.turb_velocity = ut;
    c.diameter      = d;
    return c;
  endfunction

  // Random cell shaped by the current critical Weber number: most cells sit
  // above it, some just above, some exactly on it, and the rest over the full range.
  function automatic tbr_in_t random_cell();
    logic [WORD_W-1:0] we;
    logic [WORD_W-1:0] ut;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] span;
    we   = $urandom;
    span = 32'hFFFF_FFFF - crit_shadow;
    if (span != 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: we = crit_shadow + 1 + ($urandom % span);
        4, 5:       we = (span > 256) ? crit_shadow + 32'($urandom_range(1, 256))
                                      : 32'hFFFF_FFFF;
        6:          we = crit_shadow;
        default:    we = $urandom;
      endcase
    end
    ut = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 65535)) : $urandom;
    case ($urandom_range(0, 9))
      0:       d = '0;
      1, 2:    d = 32'($urandom_range(1, 4095));
      default: d = $urandom;
    endcase
    return make_cell(we, ut, d);
  endfunction

  // Field extremes and the special cases at reset configuration.
  task automatic test_directed();
    send_cell(make_cell(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_cell(make_cell(crit_shadow, 32'hFFFF_FFFF, 32'd1));
    send_cell(make_cell(crit_shadow + 1, 32'h0100_0000, 32'h8000_0000));
    send_cell(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_cell(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
    send_cell(make_cell(32'd5, 32'h0100_0000, 32'd0));
    send_cell(make_cell(32'h0040_0000, 32'h0100_0000, 32'd1));
    send_cell(make_cell(32'h0040_0000, 32'd0, 32'd0));
    send_cell(make_cell(32'h0400_0000, 32'h0200_0000, 32'h0000_1000));
    send_cell(make_cell(32'h0200_0000, 32'h0080_0000, 32'h0100_0000));
  endtask

  // Register extremes, including a critical Weber number of zero.
  task automatic test_config_extremes();
    set_config(32'hFFFF_FFFF, 32'd1);
    send_cell(make_cell(32'd1, 32'hFFFF_FFFF, 32'd1));
    send_cell(make_cell(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_cell(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7));
    set_config(32'd0, 32'hFFFF_FFFF);
    send_cell(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
    send_cell(make_cell(32'h0000_0001, 32'hFFFF_FFFF, 32'd1));
    set_config(32'h0100_0000, 32'd0);
    send_cell(make_cell(32'd0, 32'hFFFF_FFFF, 32'd1));
    send_cell(make_cell(32'd1, 32'h0100_0000, 32'hFFFF_FFFF));
    send_cell(make_cell(32'hFFFF_FFFF, 32'h0100_0000, 32'h0001_0000));
  endtask

  // Random cells under one register setting; the middle third of each phase
  // runs back to back with no idle cycles at all.
  task automatic test_random_phase(logic [WORD_W-1:0] coeff, logic [WORD_W-1:0] crit,
                                   int count);
    set_config(coeff, crit);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3) && (i < 2 * count / 3);
      send_cell(random_cell());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    coeff_shadow = RST_BREAKUP_COEFF;
    crit_shadow  = RST_CRITICAL_WEBER;
    error_count  = 0;
    cycle_count  = 0;
    cells_sent   = 0;
    rates_checked = 0;
    above_seen   = 0;
    sat_seen     = 0;
    no_idle      = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_random_phase(RST_BREAKUP_COEFF, RST_CRITICAL_WEBER, 330);
    test_random_phase(32'hFFFF_FFFF, 32'd1, 330);
    test_random_phase($urandom, 32'($urandom_range(1, 32'h0100_0000)), 330);
    test_random_phase($urandom, $urandom, 330);
    test_random_phase(32'h0100_0000, 32'd0, 330);
    drain_pipe();

    $display("Sent %0d cells over a range of register settings; checked %0d results,",
             cells_sent, rates_checked);
    $display("%0d above critical and %0d saturated.", above_seen, sat_seen);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tbr_pkg.sv
rtl/tbr_div_pipe.sv
rtl/turbulent_breakup_rate.sv
tb/sv/tb_top.sv
